// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the Sobel edge stream RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define SEMS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define SEMS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define SEMS_ASSERT(label, clk, rst_n, prop, msg)
`define SEMS_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// File: hw/rtl/sems_pkg.sv
// Package with constants and types of the Sobel edge magnitude stream unit.
package sems_pkg;

    localparam int LINE_WIDTH  = 512;
    localparam int COL_W       = $clog2(LINE_WIDTH);
    localparam int ROW_W       = 12;
    localparam int HEIGHT_W    = ROW_W + 1;
    localparam int PIX_W       = 8;
    localparam int LINE_DATA_W = 2 * PIX_W;
    localparam int SUM_W       = PIX_W + 2;
    localparam int GRAD_W      = SUM_W + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COL_W-1:0]    COL_LAST     = COL_W'(LINE_WIDTH - 1);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(512);
    localparam logic [PIX_W-1:0]    SAT_MAX      = PIX_W'(255);

    // One accepted pixel after classification by the front end.
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [COL_W-1:0] col;
        logic             emit;
        logic             last;
    } item_t;

endpackage

// File: hw/rtl/sobel_edge_magnitude_stream_unit.sv
// Top level of the streaming Sobel edge magnitude unit.
//
//  Channel  | Handshake             | Payload                       | Direction
//  ---------+-----------------------+-------------------------------+----------
//  input    | in_valid / in_stall   | pixel, start_of_frame         | in
//  output   | out_valid / out_stall | edge_strength, last_of_frame  | out
//  config   | cfg_valid / cfg_ready | frame_height                  | in
//
// The unit takes one pixel per clock cycle and sustains one transaction per cycle
// on both channels while no stall holds the flow; a result passes through the queue
// register, the registered read of the line buffer RAM and the window, gradient and
// magnitude registers.
// Reset clears the position counters, sets the frame height to 512 and empties the
// queue; line buffer contents are not cleared and only feed results once written.
// A stall on a pending output freezes the whole back pipeline; the four-entry queue keeps
// taking pixels, and in_stall rises only while that queue is full.
module sobel_edge_magnitude_stream_unit (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [sems_pkg::PIX_W-1:0]          pixel,
    input  logic                                start_of_frame,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [sems_pkg::PIX_W-1:0]          edge_strength,
    output logic                                last_of_frame,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sems_pkg::HEIGHT_W-1:0]       frame_height
);

    logic            queue_full;
    logic            queue_empty;
    logic            push;
    logic            pop;
    sems_pkg::item_t push_item;
    sems_pkg::item_t head;

    // The height register takes a write in any cycle.
    assign cfg_ready = 1'b1;
    assign in_stall  = queue_full;

    // The front end places each pixel in the frame and decides whether it yields
    // a result and whether that result closes the frame.
    sems_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .pixel          (pixel),
        .start_of_frame (start_of_frame),
        .cfg_valid      (cfg_valid && cfg_ready),
        .cfg_height     (frame_height),
        .queue_full     (queue_full),
        .push           (push),
        .push_item      (push_item)
    );

    // Classified pixels wait here so that an output stall does not reach the input
    // at once.
    sems_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (queue_full),
        .empty     (queue_empty),
        .head      (head)
    );

    // The back end updates the line buffers and window for every pixel and
    // puts out a magnitude result only for interior positions.
    sems_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .queue_empty   (queue_empty),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .edge_strength (edge_strength),
        .last_of_frame (last_of_frame)
    );

endmodule

// File: hw/rtl/sems_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sems_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Read returns the old contents when the same address is written.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/sems_front.sv
// Front end: frame height register, position counters and pixel classification.
`include "assert_macros.svh"

module sems_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic [sems_pkg::PIX_W-1:0]          pixel,
    input  logic                                start_of_frame,
    input  logic                                cfg_valid,
    input  logic [sems_pkg::HEIGHT_W-1:0]       cfg_height,
    input  logic                                queue_full,
    output logic                                push,
    output sems_pkg::item_t                     push_item
);

    logic [sems_pkg::COL_W-1:0]    column_count_reg;
    logic [sems_pkg::COL_W-1:0]    column_count_next;
    logic [sems_pkg::ROW_W-1:0]    row_count_reg;
    logic [sems_pkg::ROW_W-1:0]    row_count_next;
    logic [sems_pkg::HEIGHT_W-1:0] frame_height_reg;
    logic [sems_pkg::HEIGHT_W-1:0] frame_height_next;

    logic [sems_pkg::COL_W-1:0]    col;
    logic [sems_pkg::ROW_W-1:0]    row;
    logic [sems_pkg::HEIGHT_W-1:0] row_inc;
    logic                          row_wrap;
    logic                          emit;
    logic                          last;

    assign push = in_valid && !queue_full;

    // A start flag restarts the counters before this pixel is placed.
    assign col = start_of_frame ? '0 : column_count_reg;
    assign row = start_of_frame ? '0 : row_count_reg;

    assign emit = (row >= sems_pkg::ROW_W'(2)) && (col >= sems_pkg::COL_W'(2));
    assign last = emit && (frame_height_reg != '0)
               && ({1'b0, row} == frame_height_reg - sems_pkg::HEIGHT_W'(1))
               && (col == sems_pkg::COL_LAST);

    assign row_inc  = {1'b0, row} + sems_pkg::HEIGHT_W'(1);
    assign row_wrap = (row_inc >= frame_height_reg) || row_inc[sems_pkg::ROW_W];

    always_comb
    begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        if (push)
        begin
            if (col == sems_pkg::COL_LAST)
            begin
                column_count_next = '0;
                row_count_next    = row_wrap ? '0 : row_inc[sems_pkg::ROW_W-1:0];
            end
            else
            begin
                column_count_next = col + sems_pkg::COL_W'(1);
                row_count_next    = row;
            end
        end
    end

    assign frame_height_next = cfg_valid ? cfg_height : frame_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            frame_height_reg <= sems_pkg::HEIGHT_RESET;
        end
        else
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            frame_height_reg <= frame_height_next;
        end
    end

    always_comb
    begin
        push_item.pixel = pixel;
        push_item.col   = col;
        push_item.emit  = emit;
        push_item.last  = last;
    end

    `SEMS_ASSERT(a_col_wraps, clk, rst_n,
        push && (col == sems_pkg::COL_LAST) |=> column_count_reg == '0,
        "column count did not wrap at line end")

endmodule

// File: hw/rtl/sems_queue.sv
// Short FIFO that decouples the front end from the back end.
`include "assert_macros.svh"

module sems_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sems_pkg::item_t push_item,
    input  logic            pop,
    output logic            full,
    output logic            empty,
    output sems_pkg::item_t head
);

    sems_pkg::item_t               entry_reg [sems_pkg::QUEUE_DEPTH];
    logic [sems_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [sems_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [sems_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [sems_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [sems_pkg::QCNT_W-1:0]   count_reg;
    logic [sems_pkg::QCNT_W-1:0]   count_next;
    logic                          do_push;
    logic                          do_pop;

    assign full    = (count_reg == sems_pkg::QCNT_W'(sems_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == sems_pkg::QPTR_W'(sems_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + sems_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == sems_pkg::QPTR_W'(sems_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + sems_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + sems_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - sems_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    `SEMS_ASSERT(a_count_bound, clk, rst_n, count_reg <= sems_pkg::QCNT_W'(sems_pkg::QUEUE_DEPTH), "queue count above depth")
    `SEMS_ASSERT(a_head_holds, clk, rst_n, !empty && !pop |=> head == $past(head), "queue head changed without a pop")

endmodule

// File: hw/rtl/sems_back.sv
// Back end: line buffer RAM, 3x3 window, Sobel gradients and output register.
`include "assert_macros.svh"

module sems_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       queue_empty,
    input  sems_pkg::item_t            head,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [sems_pkg::PIX_W-1:0] edge_strength,
    output logic                       last_of_frame
);

    localparam int PW = sems_pkg::PIX_W;

    logic advance;

    // Stage 1: item whose line buffer read is in flight.
    logic                             s1_valid_reg;
    sems_pkg::item_t                  s1_item_reg;
    logic                             s1_fwd_hit_reg;
    logic [sems_pkg::LINE_DATA_W-1:0] s1_fwd_data_reg;
    logic [sems_pkg::LINE_DATA_W-1:0] ram_rd_data;
    logic [sems_pkg::LINE_DATA_W-1:0] line_pair;
    logic [PW-1:0]                    line_top;
    logic [PW-1:0]                    line_mid;

    // Stage 2: window, stage 3: gradients, then the output register.
    logic [PW-1:0]                    window_reg [9];
    logic                             s2_valid_reg;
    logic                             s2_last_reg;
    logic                             s3_valid_reg;
    logic                             s3_last_reg;
    logic signed [sems_pkg::GRAD_W-1:0] gx_reg;
    logic signed [sems_pkg::GRAD_W-1:0] gy_reg;
    logic                             out_valid_reg;
    logic [PW-1:0]                    edge_reg;
    logic                             last_reg;

    logic [sems_pkg::SUM_W-1:0]       gx_pos;
    logic [sems_pkg::SUM_W-1:0]       gx_neg;
    logic [sems_pkg::SUM_W-1:0]       gy_pos;
    logic [sems_pkg::SUM_W-1:0]       gy_neg;
    logic signed [sems_pkg::GRAD_W-1:0] gx;
    logic signed [sems_pkg::GRAD_W-1:0] gy;
    logic [sems_pkg::GRAD_W-1:0]      gx_abs;
    logic [sems_pkg::GRAD_W-1:0]      gy_abs;
    logic [sems_pkg::GRAD_W:0]        abs_sum;
    logic [PW-1:0]                    magnitude;

    // The whole back pipeline moves unless a finished result is held up.
    assign advance = !out_valid_reg || !out_stall;
    assign pop     = advance && !queue_empty;

    // One RAM entry holds the pixel two rows up and one row up for a column.
    sems_ram #(
        .WIDTH (sems_pkg::LINE_DATA_W),
        .DEPTH (sems_pkg::LINE_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (advance && s1_valid_reg),
        .wr_addr (s1_item_reg.col),
        .wr_data ({line_mid, s1_item_reg.pixel}),
        .rd_en   (pop),
        .rd_addr (head.col),
        .rd_data (ram_rd_data)
    );

    // A read that collided with the write of the item just ahead takes the new data.
    assign line_pair = s1_fwd_hit_reg ? s1_fwd_data_reg : ram_rd_data;
    assign line_top  = line_pair[sems_pkg::LINE_DATA_W-1:PW];
    assign line_mid  = line_pair[PW-1:0];

    always_comb
    begin
        gx_pos = sems_pkg::SUM_W'(window_reg[2]) + {1'b0, window_reg[5], 1'b0}
               + sems_pkg::SUM_W'(window_reg[8]);
        gx_neg = sems_pkg::SUM_W'(window_reg[0]) + {1'b0, window_reg[3], 1'b0}
               + sems_pkg::SUM_W'(window_reg[6]);
        gy_pos = sems_pkg::SUM_W'(window_reg[6]) + {1'b0, window_reg[7], 1'b0}
               + sems_pkg::SUM_W'(window_reg[8]);
        gy_neg = sems_pkg::SUM_W'(window_reg[0]) + {1'b0, window_reg[1], 1'b0}
               + sems_pkg::SUM_W'(window_reg[2]);
        gx = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
        gy = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
    end

    always_comb
    begin
        gx_abs    = gx_reg[sems_pkg::GRAD_W-1] ? -gx_reg : gx_reg;
        gy_abs    = gy_reg[sems_pkg::GRAD_W-1] ? -gy_reg : gy_reg;
        abs_sum   = {1'b0, gx_abs} + {1'b0, gy_abs};
        magnitude = (abs_sum > (sems_pkg::GRAD_W + 1)'(sems_pkg::SAT_MAX))
                  ? sems_pkg::SAT_MAX : abs_sum[PW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= pop;
            s2_valid_reg  <= s1_valid_reg && s1_item_reg.emit;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_item_reg     <= head;
            s1_fwd_hit_reg  <= s1_valid_reg && (s1_item_reg.col == head.col);
            s1_fwd_data_reg <= {line_mid, s1_item_reg.pixel};
            if (s1_valid_reg)
            begin
                window_reg[0] <= window_reg[1];
                window_reg[1] <= window_reg[2];
                window_reg[2] <= line_top;
                window_reg[3] <= window_reg[4];
                window_reg[4] <= window_reg[5];
                window_reg[5] <= line_mid;
                window_reg[6] <= window_reg[7];
                window_reg[7] <= window_reg[8];
                window_reg[8] <= s1_item_reg.pixel;
            end
            s2_last_reg <= s1_item_reg.last;
            gx_reg      <= gx;
            gy_reg      <= gy;
            s3_last_reg <= s2_last_reg;
            edge_reg    <= magnitude;
            last_reg    <= s3_last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign edge_strength = edge_reg;
    assign last_of_frame = last_reg;

    `SEMS_ASSERT(a_fwd_on_collision, clk, rst_n, pop && s1_valid_reg && (s1_item_reg.col == head.col) |=> s1_fwd_hit_reg, "line buffer collision not forwarded")
    `SEMS_ASSERT(a_result_from_item, clk, rst_n, $rose(out_valid_reg) |-> $past(s3_valid_reg), "result without a gradient stage item")
    `SEMS_ASSERT(a_window_holds, clk, rst_n, !advance |=> $stable(s1_valid_reg) && $stable(s2_valid_reg) && $stable(s3_valid_reg), "back pipeline moved while held")

endmodule

// File: sim/sobel_edge_magnitude_stream_checker.sv
// Checker for the Sobel edge stream unit: predicts edge results and compares them.
module sobel_edge_magnitude_stream_checker
    import sems_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [PIX_W-1:0]    pixel,
    input  logic                start_of_frame,

    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [PIX_W-1:0]    edge_strength,
    input  logic                last_of_frame,

    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [HEIGHT_W-1:0] frame_height,

    output int                  outstanding,
    output int                  failures,
    output int                  pixels_taken,
    output int                  edges_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_LIMIT   = 1 << ROW_W;
    localparam int SHOW_LIMIT  = 10;

    typedef struct packed {
        logic [PIX_W-1:0] strength;
        logic             last;
    } edge_result_t;

    // Shadow copy of the unit's state.
    logic [PIX_W-1:0]    two_up [LINE_WIDTH];
    logic [PIX_W-1:0]    one_up [LINE_WIDTH];
    logic [PIX_W-1:0]    nbhd [9];
    int                  col_pos;
    int                  row_pos;
    logic [HEIGHT_W-1:0] rows_per_frame;

    edge_result_t        expected_edges [$];
    int                  mismatch_total;
    int                  pixel_total;
    int                  edge_total;

    // Take one pixel into the shadow state and queue the edge result it causes, if any.
    task automatic take_pixel(input logic [PIX_W-1:0] pix, input logic sof);
        int           c;
        int           r;
        int           gx;
        int           gy;
        int           mag;
        logic [PIX_W-1:0] top_px;
        logic [PIX_W-1:0] mid_px;
        edge_result_t res;
        if (sof)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        c = col_pos;
        r = row_pos;
        top_px    = two_up[c];
        mid_px    = one_up[c];
        two_up[c] = mid_px;
        one_up[c] = pix;

        // Window row 0 is the oldest line; the new column enters on the right.
        nbhd[0] = nbhd[1]; nbhd[1] = nbhd[2]; nbhd[2] = top_px;
        nbhd[3] = nbhd[4]; nbhd[4] = nbhd[5]; nbhd[5] = mid_px;
        nbhd[6] = nbhd[7]; nbhd[7] = nbhd[8]; nbhd[8] = pix;

        if (r >= 2 && c >= 2)
        begin
            gx = (int'(nbhd[2]) + 2 * int'(nbhd[5]) + int'(nbhd[8]))
               - (int'(nbhd[0]) + 2 * int'(nbhd[3]) + int'(nbhd[6]));
            gy = (int'(nbhd[6]) + 2 * int'(nbhd[7]) + int'(nbhd[8]))
               - (int'(nbhd[0]) + 2 * int'(nbhd[1]) + int'(nbhd[2]));
            mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
            if (mag > int'(SAT_MAX))
                mag = int'(SAT_MAX);
            res.strength = PIX_W'(mag);
            res.last     = (rows_per_frame != '0) && (r == int'(rows_per_frame) - 1)
                           && (c == LINE_WIDTH - 1);
            expected_edges.push_back(res);
        end

        c = c + 1;
        if (c >= LINE_WIDTH)
        begin
            c = 0;
            r = r + 1;
            if (r >= int'(rows_per_frame) || r >= ROW_LIMIT)
                r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        edge_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < LINE_WIDTH; i++)
            begin
                two_up[i] = '0;
                one_up[i] = '0;
            end
            for (int i = 0; i < 9; i++)
                nbhd[i] = '0;
            col_pos        = 0;
            row_pos        = 0;
            rows_per_frame = HEIGHT_RESET;
            expected_edges.delete();
            mismatch_total = 0;
            pixel_total    = 0;
            edge_total     = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                edge_total++;
                if (expected_edges.size() == 0)
                begin
                    mismatch_total++;
                    if (mismatch_total <= SHOW_LIMIT)
                        $display("%0t: unexpected result edge_strength=%0d last_of_frame=%0b",
                                 $realtime, edge_strength, last_of_frame);
                end
                else
                begin
                    want = expected_edges.pop_front();
                    if (edge_strength !== want.strength || last_of_frame !== want.last)
                    begin
                        mismatch_total++;
                        if (mismatch_total <= SHOW_LIMIT)
                            $display({"%0t: result mismatch: edge_strength exp %0d got %0d, ",
                                      "last_of_frame exp %0b got %0b"}, $realtime,
                                     want.strength, edge_strength, want.last, last_of_frame);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                rows_per_frame = frame_height;
            if (in_valid && !in_stall)
            begin
                pixel_total++;
                take_pixel(pixel, start_of_frame);
            end
        end
        outstanding   <= expected_edges.size();
        failures      <= mismatch_total;
        pixels_taken  <= pixel_total;
        edges_checked <= edge_total;
    end

endmodule

// File: sim/sobel_edge_magnitude_stream_unit_tb.sv
// Testbench top for the Sobel edge stream unit: stimulus, stalls and the verdict.
module sobel_edge_magnitude_stream_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sems_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 12;
    // Pixels that give no result can still sit in the pipeline when the last
    // expected result has arrived, so a height write waits this long first.
    localparam int DRAIN_CYCLES  = 24;
    localparam int TAIL_CYCLES   = 40;
    localparam int LONG_HOLD     = 400;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int RANDOM_FRAMES = 8;
    localparam int QUIET_FRAMES  = 2;

    // Content patterns for the frames that are sent.
    typedef enum int {
        PAT_STRIPES,    // vertical stripes two columns wide, 0 and 255
        PAT_STEP,       // dark frame with one bright row at row 2
        PAT_RAMP,       // value equals the column modulo 256, small gradients
        PAT_NOISE,      // uniform random pixels
        PAT_SOFT,       // low contrast noise around a random level
        PAT_BINARY      // random choice between 0 and 255
    } pattern_t;

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                in_valid       = 1'b0;
    logic                in_stall;
    logic [PIX_W-1:0]    pixel          = '0;
    logic                start_of_frame = 1'b0;
    logic                out_valid;
    logic                out_stall      = 1'b0;
    logic [PIX_W-1:0]    edge_strength;
    logic                last_of_frame;
    logic                cfg_valid      = 1'b0;
    logic                cfg_ready;
    logic [HEIGHT_W-1:0] frame_height   = '0;

    int outstanding;
    int failures;
    int pixels_taken;
    int edges_checked;

    // Idling controls shared between the stimulus and the receiver process.
    bit tx_jitter    = 1'b0;
    bit rx_jitter    = 1'b0;
    bit hold_request = 1'b0;
    int cycle_count  = 0;
    int heights_set  = 0;
    int passes       = 0;

    always #CLK_HALF clk = ~clk;

    sobel_edge_magnitude_stream_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .pixel          (pixel),
        .start_of_frame (start_of_frame),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .edge_strength  (edge_strength),
        .last_of_frame  (last_of_frame),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .frame_height   (frame_height)
    );

    sobel_edge_magnitude_stream_checker edge_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .pixel          (pixel),
        .start_of_frame (start_of_frame),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .edge_strength  (edge_strength),
        .last_of_frame  (last_of_frame),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .frame_height   (frame_height),
        .outstanding    (outstanding),
        .failures       (failures),
        .pixels_taken   (pixels_taken),
        .edges_checked  (edges_checked)
    );

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d results still awaited",
                     cycle_count, outstanding);
            $display("sobel_edge_magnitude_stream_unit_tb: FAIL");
            $finish;
        end
    end

    // Receiver side. Random stall bursts while jitter is enabled, and one long
    // hold-off on request so that the internal queue fills up and the unit
    // stalls its input while the sender keeps offering pixels.
    initial
    begin : receiver
        int burst;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (rx_jitter && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 9);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic logic [PIX_W-1:0] pattern_pixel(input pattern_t pat, input int r,
                                                       input int c, input logic [PIX_W-1:0] base);
        case (pat)
            PAT_STRIPES: return c[1] ? 8'hFF : 8'h00;
            PAT_STEP:    return (r == 2) ? 8'hFF : 8'h00;
            PAT_RAMP:    return PIX_W'(c);
            PAT_NOISE:   return PIX_W'($urandom_range(0, 255));
            PAT_SOFT:    return base + PIX_W'($urandom_range(0, 15));
            default:     return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        endcase
    endfunction

    // Offer one pixel and hold it until the unit takes the transaction.
    // Valid stays high afterwards so that back-to-back pixels need no gap.
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic sof);
        int gap;
        if (tx_jitter && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 9);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        pixel          <= pix;
        start_of_frame <= sof;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Send whole rows in raster order. The start flag goes on the first pixel
    // when asked for; a broken sequence can also get a stray start flag.
    task automatic send_rows(input pattern_t pat, input int rows, input bit mark_start,
                             input bit stray_starts);
        logic [PIX_W-1:0] base;
        logic             sof;
        base = PIX_W'($urandom_range(0, 240));
        for (int r = 0; r < rows; r++)
        begin
            for (int c = 0; c < LINE_WIDTH; c++)
            begin
                sof = (mark_start && r == 0 && c == 0) ||
                      (stray_starts && $urandom_range(0, 1499) == 0);
                send_pixel(pattern_pixel(pat, r, c, base), sof);
            end
        end
        passes++;
    endtask

    // The height register is only written while the unit is idle: every
    // expected result has come out and the pipeline had time to empty.
    task automatic set_frame_height(input logic [HEIGHT_W-1:0] h);
        bit rx_keep;
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        rx_keep   = rx_jitter;
        rx_jitter = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid    <= 1'b1;
        frame_height <= h;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        rx_jitter = rx_keep;
        heights_set++;
    endtask

    initial
    begin : stimulus
        int       pick;
        int       h;
        int       rows;
        pattern_t pat;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_jitter = 1'b1;
        rx_jitter = 1'b1;

        // Directed part. Smallest height with results: saturating horizontal gradients,
        // then a second frame that starts only because the row counter wraps.
        set_frame_height(HEIGHT_W'(3));
        send_rows(PAT_STRIPES, 3, 1'b1, 1'b0);
        send_rows(PAT_STEP, 3, 1'b0, 1'b0);

        // Gentle ramp gives small magnitudes, saturated only where the column value wraps.
        set_frame_height(HEIGHT_W'(4));
        send_rows(PAT_RAMP, 4, 1'b1, 1'b0);

        // Heights below three have no interior position, so no result at all.
        set_frame_height(HEIGHT_W'(0));
        send_rows(PAT_NOISE, 1, 1'b1, 1'b0);
        set_frame_height(HEIGHT_W'(1));
        send_rows(PAT_NOISE, 1, 1'b1, 1'b0);
        set_frame_height(HEIGHT_W'(2));
        send_rows(PAT_BINARY, 2, 1'b1, 1'b0);

        // All-ones height lies above the row counter range; last is never set.
        set_frame_height({HEIGHT_W{1'b1}});
        send_rows(PAT_NOISE, 3, 1'b1, 1'b0);

        // Tallest legal frame, cut short by a start flag in the middle of it.
        set_frame_height(HEIGHT_W'(4096));
        send_rows(PAT_NOISE, 3, 1'b1, 1'b0);
        send_rows(PAT_BINARY, 3, 1'b1, 1'b0);

        // Random part: mostly well-formed frames of small height with random
        // content, some without a start flag and some with stray start flags.
        for (int f = 0; f < RANDOM_FRAMES; f++)
        begin
            if (f >= RANDOM_FRAMES - QUIET_FRAMES)
            begin
                tx_jitter = 1'b0;
                rx_jitter = 1'b0;
            end
            else
            begin
                tx_jitter = ($urandom_range(0, 3) != 0);
                rx_jitter = ($urandom_range(0, 3) != 0);
            end

            if (f == 1)
            begin
                // Long receiver hold-off in the middle of a frame with results.
                set_frame_height(HEIGHT_W'(4));
                send_rows(PAT_SOFT, 2, 1'b1, 1'b0);
                hold_request = 1'b1;
                send_rows(PAT_NOISE, 2, 1'b0, 1'b0);
                continue;
            end

            if (f == 0 || $urandom_range(0, 1) == 0)
            begin
                pick = $urandom_range(0, 9);
                if (pick <= 5)
                    h = $urandom_range(3, 5);
                else if (pick == 6)
                    h = 6;
                else if (pick == 7)
                    h = $urandom_range(0, 2);
                else if (pick == 8)
                    h = 4096;
                else
                    h = $urandom_range(4097, 8191);
                set_frame_height(HEIGHT_W'(h));
            end
            else
                h = int'(frame_height);

            rows = (h >= 3 && h <= 6) ? h + $urandom_range(0, 1) : 3;
            pick = $urandom_range(0, 9);
            if (pick <= 3)
                pat = PAT_SOFT;
            else if (pick <= 6)
                pat = PAT_NOISE;
            else if (pick <= 8)
                pat = PAT_BINARY;
            else
                pat = PAT_STRIPES;
            send_rows(pat, rows, $urandom_range(0, 4) != 0, $urandom_range(0, 4) == 0);
        end

        // Drain: wait for every expected result, then wait out the tail for strays.
        in_valid <= 1'b0;
        tx_jitter = 1'b0;
        rx_jitter = 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d pixels in %0d row groups, %0d edge results checked,",
                 pixels_taken, passes, edges_checked);
        $display("%0d height writes (0, 1, 2, 3, 4, 4096, all ones), one long output hold-off",
                 heights_set);
        if (failures == 0 && outstanding == 0)
            $display("sobel_edge_magnitude_stream_unit_tb: PASS");
        else
            $display("sobel_edge_magnitude_stream_unit_tb: FAIL");
        $finish;
    end

endmodule
